/* sv/zbb_pkg.sv */
`timescale 1ns / 1ps

package zbb_pkg;

    // Operation codes, as carried in the kind field.
    typedef enum logic [4:0] {
        OP_ANDN  = 5'd0,
        OP_CLZ   = 5'd1,
        OP_CPOP  = 5'd2,
        OP_CTZ   = 5'd3,
        OP_MAX   = 5'd4,
        OP_MAXU  = 5'd5,
        OP_MIN   = 5'd6,
        OP_MINU  = 5'd7,
        OP_ORCB  = 5'd8,
        OP_ORN   = 5'd9,
        OP_REV8  = 5'd10,
        OP_ROL   = 5'd11,
        OP_ROR   = 5'd12,
        OP_RORI  = 5'd13,
        OP_SEXTB = 5'd14,
        OP_SEXTH = 5'd15,
        OP_XNOR  = 5'd16,
        OP_ZEXTH = 5'd17,
        OP_CLZW  = 5'd18,
        OP_CPOPW = 5'd19,
        OP_CTZW  = 5'd20,
        OP_ROLW  = 5'd21,
        OP_RORIW = 5'd22,
        OP_RORW  = 5'd23
    } t_op;

    localparam logic [4:0] KIND_FIRST_WORD = 5'd18;
    localparam logic [4:0] KIND_LAST       = 5'd23;

    localparam int XLEN     = 64;
    localparam int CNT_W    = 7;   // holds 0..64
    localparam logic [7:0] BYTE_ONES = 8'hFF;

endpackage

/* sv/zbb_cnt.sv */
`timescale 1ns / 1ps

// Two-level counter: byte partials registered, totals combined after the register.
module zbb_cnt (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [zbb_pkg::XLEN-1:0]    i_tz_src,
    input  logic [zbb_pkg::XLEN-1:0]    i_pop_src,
    output logic [zbb_pkg::CNT_W-1:0]   o_tz,
    output logic [zbb_pkg::CNT_W-1:0]   o_pop
);

    logic [7:0][3:0] n_pop_b, r_pop_b;
    logic [7:0][2:0] n_tz_b,  r_tz_b;
    logic [7:0]      n_nz,    r_nz;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_pop_b[i] = 4'd0;
            n_tz_b[i]  = 3'd0;
            for (int j = 0; j < 8; j++) begin
                n_pop_b[i] = n_pop_b[i] + {3'b000, i_pop_src[8*i+j]};
            end
            for (int j = 7; j >= 0; j--) begin
                if (i_tz_src[8*i+j]) begin
                    n_tz_b[i] = 3'(j);
                end
            end
            n_nz[i] = |i_tz_src[8*i +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pop_b <= n_pop_b;
            r_tz_b  <= n_tz_b;
            r_nz    <= n_nz;
        end
    end

    always_comb begin
        o_pop = '0;
        for (int i = 0; i < 8; i++) begin
            o_pop = o_pop + {3'b000, r_pop_b[i]};
        end
        // lowest nonzero byte wins; all zero gives the full width
        o_tz = 7'd64;
        for (int i = 7; i >= 0; i--) begin
            if (r_nz[i]) begin
                o_tz = {1'b0, 3'(i), r_tz_b[i]};
            end
        end
    end

endmodule

/* sv/zbb_bitmanip_alu.sv */
`timescale 1ns / 1ps

// RISC-V Zbb bit-manipulation ALU, three-stage pipeline.
// Slave channel: s_tuser = kind (operation code); s_tdata = first_operand,
// second_operand, shift_immediate from the low bit up, zero padded to 136 bits.
// Master channel: m_tdata = dest_value; m_tuser = illegal_op.
// Config: i_cfg_we / i_cfg_wdata write wide_mode (1 = 64-bit, 0 = 32-bit);
// write only while the pipeline is empty.
// Order: an accepted transaction passes the stage 1, stage 2 and output
// registers in turn before its result shows on the master side.
// Throughput: one transaction per cycle while m_tready is high, set by the stage
// registers; no operation iterates.
// Stage 1: decode, operand masking, rotate amount.
// Stage 2: logic/rotate/compare results, per-byte count partials.
// Stage 3: count totals, final select (output register).
// Stall: each stage holds while the next is full and not advancing; the
// master register holds its result until m_tready, nothing dropped or repeated.
// Reset: pipeline emptied, wide_mode returns to 1 (64-bit).
module zbb_bitmanip_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,   // [63:0] first_operand, [127:64] second_operand,
                                     // [133:128] shift_immediate, [135:134] zero
    input  logic [4:0]    s_tuser,   // [4:0] kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // [63:0] dest_value
    output logic          m_tuser    // [0] illegal_op
);

    localparam int W = zbb_pkg::XLEN;

    logic r_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else if (i_cfg_we) begin
            r_wide <= i_cfg_wdata;
        end
    end

    // Handshake: a stage loads when it is empty or the next one moves on.
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !r_v3 || m_tready;
    assign rdy2     = !r_v2 || rdy3;
    assign rdy1     = !r_v1 || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // ---------------- Stage 1: decode ----------------
    logic [W-1:0]    in_a, in_b, wmask;
    logic [5:0]      in_imm;
    logic [4:0]      in_kind;
    logic            n_ill1;
    zbb_pkg::t_op    n_op1;
    logic            n_word1;
    logic            n_rot32;
    logic [5:0]      rot_src, n_amt;

    assign in_a    = s_tdata[63:0];
    assign in_b    = s_tdata[127:64];
    assign in_imm  = s_tdata[133:128];
    assign in_kind = s_tuser;
    assign wmask   = r_wide ? {W{1'b1}} : {32'h0, 32'hFFFF_FFFF};

    always_comb begin
        n_ill1  = (in_kind > zbb_pkg::KIND_LAST) ||
                  ((in_kind >= zbb_pkg::KIND_FIRST_WORD) && !r_wide);
        n_op1   = n_ill1 ? zbb_pkg::OP_ANDN : zbb_pkg::t_op'(in_kind);
        n_word1 = (in_kind >= zbb_pkg::KIND_FIRST_WORD);
        n_rot32 = !r_wide || n_word1;

        rot_src = in_b[5:0];
        if (n_op1 == zbb_pkg::OP_RORI || n_op1 == zbb_pkg::OP_RORIW) begin
            rot_src = in_imm;
        end
        // right rotates become left rotates by the negated amount
        if (n_op1 == zbb_pkg::OP_ROL || n_op1 == zbb_pkg::OP_ROLW) begin
            n_amt = rot_src;
        end else begin
            n_amt = 6'd0 - rot_src;
        end
        if (n_rot32) begin
            n_amt[5] = 1'b0;
        end
    end

    logic [W-1:0]  r1_a, r1_b;
    zbb_pkg::t_op  r1_op;
    logic          r1_ill, r1_wide, r1_rot32;
    logic [5:0]    r1_amt;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_a     <= in_a & wmask;
            r1_b     <= in_b & wmask;
            r1_op    <= n_op1;
            r1_ill   <= n_ill1;
            r1_wide  <= r_wide;
            r1_rot32 <= n_rot32;
            r1_amt   <= n_amt;
        end
    end

    // ---------------- Stage 2: main datapath ----------------
    logic [W-1:0]   m2, bias, ax, bx, rot, orcb, rev, n_simple;
    logic [W-1:0]   tz_src, pop_src, rev_a;
    logic [31:0]    rev_a32;
    logic [127:0]   rot64_w;
    logic [63:0]    rot32_w;
    logic           ge_s, le_s, ge_u, le_u;

    always_comb begin
        m2   = r1_wide ? {W{1'b1}} : {32'h0, 32'hFFFF_FFFF};
        bias = r1_wide ? {1'b1, 63'h0} : {32'h0, 32'h8000_0000};
        ax   = r1_a ^ bias;
        bx   = r1_b ^ bias;
        ge_s = ax >= bx;
        le_s = ax <= bx;
        ge_u = r1_a >= r1_b;
        le_u = r1_a <= r1_b;

        rot64_w = {r1_a, r1_a} << r1_amt;
        rot32_w = {r1_a[31:0], r1_a[31:0]} << r1_amt[4:0];
        if (r1_rot32) begin
            rot = {{32{rot32_w[63]}}, rot32_w[63:32]};
        end else begin
            rot = rot64_w[127:64];
        end

        for (int i = 0; i < 8; i++) begin
            orcb[8*i +: 8] = (|r1_a[8*i +: 8]) ? zbb_pkg::BYTE_ONES : 8'h00;
        end
        if (r1_wide) begin
            for (int i = 0; i < 8; i++) begin
                rev[8*i +: 8] = r1_a[8*(7-i) +: 8];
            end
        end else begin
            rev[63:32] = 32'h0;
            for (int i = 0; i < 4; i++) begin
                rev[8*i +: 8] = r1_a[8*(3-i) +: 8];
            end
        end

        unique case (r1_op)
            zbb_pkg::OP_ANDN:  n_simple = r1_a & ~r1_b;
            zbb_pkg::OP_ORN:   n_simple = r1_a | ~r1_b;
            zbb_pkg::OP_XNOR:  n_simple = ~(r1_a ^ r1_b);
            zbb_pkg::OP_MAX:   n_simple = ge_s ? r1_a : r1_b;
            zbb_pkg::OP_MAXU:  n_simple = ge_u ? r1_a : r1_b;
            zbb_pkg::OP_MIN:   n_simple = le_s ? r1_a : r1_b;
            zbb_pkg::OP_MINU:  n_simple = le_u ? r1_a : r1_b;
            zbb_pkg::OP_ORCB:  n_simple = orcb;
            zbb_pkg::OP_REV8:  n_simple = rev;
            zbb_pkg::OP_ROL,
            zbb_pkg::OP_ROR,
            zbb_pkg::OP_RORI,
            zbb_pkg::OP_ROLW,
            zbb_pkg::OP_RORW,
            zbb_pkg::OP_RORIW: n_simple = rot;
            zbb_pkg::OP_SEXTB: n_simple = {{56{r1_a[7]}}, r1_a[7:0]};
            zbb_pkg::OP_SEXTH: n_simple = {{48{r1_a[15]}}, r1_a[15:0]};
            zbb_pkg::OP_ZEXTH: n_simple = {48'h0, r1_a[15:0]};
            default:           n_simple = '0;   // counts come from zbb_cnt
        endcase
        n_simple = n_simple & m2;

        // leading zeros counted as trailing zeros of the bit-reversed operand
        for (int i = 0; i < W; i++) begin
            rev_a[i] = r1_a[W-1-i];
        end
        for (int i = 0; i < 32; i++) begin
            rev_a32[i] = r1_a[31-i];
        end
        // in 32-bit width a guard bit at 32 caps the count at 32
        unique case (r1_op)
            zbb_pkg::OP_CLZ:  tz_src = r1_wide ? rev_a : {31'h0, 1'b1, rev_a32};
            zbb_pkg::OP_CLZW: tz_src = {31'h0, 1'b1, rev_a32};
            zbb_pkg::OP_CTZ:  tz_src = r1_wide ? r1_a : {31'h0, 1'b1, r1_a[31:0]};
            default:          tz_src = {31'h0, 1'b1, r1_a[31:0]};
        endcase
        pop_src = (r1_op == zbb_pkg::OP_CPOPW) ? {32'h0, r1_a[31:0]} : r1_a;
    end

    logic [W-1:0]  r2_simple;
    zbb_pkg::t_op  r2_op;
    logic          r2_ill;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_simple <= n_simple;
            r2_op     <= r1_op;
            r2_ill    <= r1_ill;
        end
    end

    logic [zbb_pkg::CNT_W-1:0] cnt_tz, cnt_pop;

    zbb_cnt u_cnt (
        .i_clk     (i_clk),
        .i_load    (rdy2),
        .i_tz_src  (tz_src),
        .i_pop_src (pop_src),
        .o_tz      (cnt_tz),
        .o_pop     (cnt_pop)
    );

    // ---------------- Stage 3: select, output register ----------------
    logic [W-1:0] n_res;

    always_comb begin
        unique case (r2_op)
            zbb_pkg::OP_CLZ,
            zbb_pkg::OP_CTZ,
            zbb_pkg::OP_CLZW,
            zbb_pkg::OP_CTZW:  n_res = {{(W-zbb_pkg::CNT_W){1'b0}}, cnt_tz};
            zbb_pkg::OP_CPOP,
            zbb_pkg::OP_CPOPW: n_res = {{(W-zbb_pkg::CNT_W){1'b0}}, cnt_pop};
            default:           n_res = r2_simple;
        endcase
        if (r2_ill) begin
            n_res = '0;
        end
    end

    logic [W-1:0] r3_res;
    logic         r3_ill;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_res <= n_res;
            r3_ill <= r2_ill;
        end
    end

    assign m_tvalid = r_v3;
    assign m_tdata  = r3_res;
    assign m_tuser  = r3_ill;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Zbb bitmanip ALU: a few directed instructions in both register widths, then
// random instructions in phases that vary the mode and the idling on both sides.
// Every result transaction is checked against a predicted or written-out result.
module testbench;

    localparam int  HOLD_CYCLES   = 60;    // long master-side hold-off
    localparam int  PIPE_LATENCY  = 4;     // drain wait before a width change and at the end
    localparam int  WATCHDOG_MAX  = 5000;  // cycles with no transaction at all
    localparam int  PHASE_ITEMS   = 160;
    localparam int  NUM_PHASES    = 6;
    localparam int  MAX_REPORTS   = 10;
    // highest code a 5-bit kind can carry; codes above KIND_LAST are unused
    localparam logic [4:0] KIND_MAX_CODE = 5'd31;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] rs1;
        logic [63:0] rs2;
        logic [5:0]  shamt;
    } t_instr;

    typedef struct packed {
        logic [63:0] rd_value;
        logic        illegal;
    } t_result;

    typedef struct {
        logic        wide;
        t_instr      instr;
        logic        typed;     // result written out below instead of predicted
        t_result     result;
    } t_directed_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_wdata = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [135:0]  s_tdata = '0;   // [63:0] rs1, [127:64] rs2, [133:128] shamt, [135:134] 0
    logic [4:0]    s_tuser = '0;   // [4:0] kind
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;        // [63:0] rd value
    logic          m_tuser;        // [0] illegal op

    zbb_bitmanip_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_result       pending_results[$];   // expected results, oldest first
    t_directed_row directed_rows[$];
    logic          wide_sel = 1'b1;      // predictor copy of wide_mode, reset value
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;    // bumped by the sender to ask for a hold-off
    int            hold_served = 0;
    int            hold_left = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic logic [63:0] count_leading(input logic [63:0] x, input int w);
        int n;
        int i;
        n = 0;
        for (i = w - 1; i >= 0 && !x[i]; i--)
            n++;
        return 64'(n);
    endfunction

    function automatic logic [63:0] count_trailing(input logic [63:0] x, input int w);
        int n;
        int i;
        n = 0;
        for (i = 0; i < w && !x[i]; i++)
            n++;
        return 64'(n);
    endfunction

    function automatic logic [63:0] count_ones(input logic [63:0] x, input int w);
        int n;
        int i;
        n = 0;
        for (i = 0; i < w; i++)
            n += int'(x[i]);
        return 64'(n);
    endfunction

    // s is already reduced below w; a shift by the full width yields zero
    function automatic logic [63:0] rotate_right(input logic [63:0] x, input int s,
                                                 input int w);
        logic [31:0] x32;
        x32 = x[31:0];
        if (w == 64)
            return (x >> s) | (x << (64 - s));
        x32 = (x32 >> s) | (x32 << (32 - s));
        return {32'b0, x32};
    endfunction

    function automatic logic [63:0] sext_word(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic t_result compute_zbb(input t_instr ins, input logic wide);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] res;
        logic        bad;
        logic        less_s;
        int          w;
        int          nb;
        int          amt;
        int          i;
        w = wide ? 64 : 32;
        nb = w / 8;
        a = wide ? ins.rs1 : {32'b0, ins.rs1[31:0]};
        b = wide ? ins.rs2 : {32'b0, ins.rs2[31:0]};
        less_s = wide ? ($signed(a) < $signed(b)) : ($signed(a[31:0]) < $signed(b[31:0]));
        res = '0;
        bad = 1'b0;
        // word forms do not exist at 32-bit width
        if (!wide && ins.kind >= zbb_pkg::KIND_FIRST_WORD) begin
            bad = 1'b1;
        end else begin
            case (ins.kind)
                zbb_pkg::OP_ANDN:  res = a & ~b;
                zbb_pkg::OP_CLZ:   res = count_leading(a, w);
                zbb_pkg::OP_CPOP:  res = count_ones(a, w);
                zbb_pkg::OP_CTZ:   res = count_trailing(a, w);
                zbb_pkg::OP_MAX:   res = less_s ? b : a;
                zbb_pkg::OP_MAXU:  res = (a < b) ? b : a;
                zbb_pkg::OP_MIN:   res = less_s ? a : b;
                zbb_pkg::OP_MINU:  res = (a < b) ? a : b;
                zbb_pkg::OP_ORCB: begin
                    for (i = 0; i < nb; i++)
                        res[8*i +: 8] = (a[8*i +: 8] != 8'h00) ? zbb_pkg::BYTE_ONES : 8'h00;
                end
                zbb_pkg::OP_ORN:   res = a | ~b;
                zbb_pkg::OP_REV8: begin
                    for (i = 0; i < nb; i++)
                        res[8*(nb-1-i) +: 8] = a[8*i +: 8];
                end
                zbb_pkg::OP_ROL: begin
                    amt = int'(b[5:0]) & (w - 1);
                    res = rotate_right(a, (w - amt) & (w - 1), w);
                end
                zbb_pkg::OP_ROR: begin
                    amt = int'(b[5:0]) & (w - 1);
                    res = rotate_right(a, amt, w);
                end
                zbb_pkg::OP_RORI: begin
                    amt = int'(ins.shamt) & (w - 1);   // bit 5 dropped at 32-bit width
                    res = rotate_right(a, amt, w);
                end
                zbb_pkg::OP_SEXTB: res = {{56{a[7]}}, a[7:0]};
                zbb_pkg::OP_SEXTH: res = {{48{a[15]}}, a[15:0]};
                zbb_pkg::OP_XNOR:  res = ~(a ^ b);
                zbb_pkg::OP_ZEXTH: res = {48'b0, a[15:0]};
                zbb_pkg::OP_CLZW:  res = count_leading(a, 32);
                zbb_pkg::OP_CPOPW: res = count_ones(a, 32);
                zbb_pkg::OP_CTZW:  res = count_trailing(a, 32);
                zbb_pkg::OP_ROLW: begin
                    amt = int'(b[4:0]);
                    res = sext_word(rotate_right(a, (32 - amt) & 31, 32));
                end
                zbb_pkg::OP_RORIW: res = sext_word(rotate_right(a, int'(ins.shamt[4:0]), 32));
                zbb_pkg::OP_RORW:  res = sext_word(rotate_right(a, int'(b[4:0]), 32));
                default:  bad = 1'b1;
            endcase
        end
        if (bad)
            res = '0;
        if (!wide)
            res[63:32] = 32'b0;
        return '{rd_value: res, illegal: bad};
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic void add_row(input logic wide, input logic [4:0] kind,
                                    input logic [63:0] rs1, input logic [63:0] rs2,
                                    input logic [5:0] shamt, input logic typed,
                                    input logic [63:0] rd_value, input logic illegal);
        t_directed_row r;
        r.wide = wide;
        r.instr = '{kind: kind, rs1: rs1, rs2: rs2, shamt: shamt};
        r.typed = typed;
        r.result = '{rd_value: rd_value, illegal: illegal};
        directed_rows.push_back(r);
    endfunction

    // operand mix aimed at the counters, byte ops and sign boundaries
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        int          k;
        int          i;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            2: v = v >> k;
            3: v = v << k;
            4: v = 64'd1 << k;
            5: v = $urandom_range(0, 1) ? '1 : '0;
            6: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, v[31:0]};
            7: begin
                for (i = 0; i < 8; i++)
                    if ($urandom_range(0, 2) != 0)
                        v[8*i +: 8] = 8'h00;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_instr rand_instr();
        t_instr ins;
        if ($urandom_range(0, 9) != 0)
            ins.kind = 5'($urandom_range(0, zbb_pkg::KIND_LAST));
        else
            ins.kind = 5'($urandom_range(zbb_pkg::KIND_LAST + 1, KIND_MAX_CODE));
        ins.rs1 = rand_operand();
        ins.rs2 = ($urandom_range(0, 9) == 0) ? ins.rs1 : rand_operand();
        ins.shamt = 6'($urandom_range(0, 63));
        return ins;
    endfunction

    // Offer one instruction, wait for the slave-side transaction, record what
    // should come back, then maybe leave a gap. Valid is only lowered when a
    // gap actually follows, so back-to-back items keep it high.
    task automatic send_item(input t_instr ins, input logic typed,
                             input t_result typed_res);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ins.shamt, ins.rs2, ins.rs1};
        s_tuser  <= ins.kind;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        pending_results.push_back(typed ? typed_res : compute_zbb(ins, wide_sel));
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wide_mode may only change with the pipeline empty
    task automatic set_width(input logic wide);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wide;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        wide_sel = wide;
    endtask

    // ---------------------------------------------------------------------
    // Master side: random stall, plus a long hold-off on request so the
    // pipeline backs up into s_tready.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker: each master transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result rd=%h illegal=%b",
                             $realtime, m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.rd_value) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: rd value expected %h got %h",
                                 $realtime, want.rd_value, m_tdata);
                end
                if (m_tuser !== want.illegal) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: illegal flag expected %b got %b",
                                 $realtime, want.illegal, m_tuser);
                end
            end
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        int          p;
        int          n;
        int          phase_send[NUM_PHASES];
        int          phase_recv[NUM_PHASES];
        logic        phase_wide[NUM_PHASES];
        t_instr      ins;
        t_result     none;

        // phase 4 is the back-pressure phase; the last mixes both sides
        phase_send = '{0, 88, 0, 34, 0, 50};
        phase_recv = '{0, 0, 88, 34, 0, 50};
        phase_wide = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        none = '0;

        // Directed table. First rows run before any config write, so they
        // also confirm that reset leaves the block in 64-bit mode.
        add_row(1'b1, zbb_pkg::OP_CLZ,   64'h0, 64'h0, 6'd0, 1'b1, 64'd64, 1'b0); // zero -> width
        add_row(1'b1, zbb_pkg::OP_CTZ,   64'h0, 64'h0, 6'd0, 1'b1, 64'd64, 1'b0);
        add_row(1'b1, zbb_pkg::OP_CPOP,  '1, 64'h0, 6'd0, 1'b1, 64'd64, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ANDN,  '1, 64'h0, 6'd0, 1'b1, '1, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ORN,   64'h0, '1, 6'd0, 1'b1, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_XNOR,  64'h0123_4567_89AB_CDEF, 64'hFFFF_0000_FFFF_0000,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_MAX,   64'h8000_0000_0000_0000, 64'h1,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_MAXU,  64'h8000_0000_0000_0000, 64'h1,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_MIN,   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_MINU,  '1, 64'h0, 6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ORCB,  64'h0100_0000_0000_0080, 64'h0,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_REV8,  64'h0102_0304_0506_0708, 64'h0, 6'd0,
                1'b1, 64'h0807_0605_0403_0201, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ROL,   64'h8000_0000_0000_0001, 64'hFF,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ROR,   64'h8000_0000_0000_0001, 64'hFF,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_RORI,  64'h8000_0000_0000_0001, 64'h0,
                6'd63, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_SEXTB, 64'h80, 64'h0, 6'd0,
                1'b1, 64'hFFFF_FFFF_FFFF_FF80, 1'b0);
        add_row(1'b1, zbb_pkg::OP_SEXTH, 64'h1234_5678_9ABC_8000, 64'h0,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ZEXTH, '1, 64'h0, 6'd0, 1'b1, 64'hFFFF, 1'b0);
        add_row(1'b1, zbb_pkg::OP_CLZW,  64'hFFFF_FFFF_0000_0000, 64'h0,
                6'd0, 1'b1, 64'd32, 1'b0);
        add_row(1'b1, zbb_pkg::OP_CPOPW, '1, 64'h0, 6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_CTZW,  64'h0000_0001_0000_0000, 64'h0,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_ROLW,  64'h0000_0000_4000_0000, 64'h1,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_RORIW, 64'h0000_0000_0000_0001, 64'h0,
                6'd63, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, zbb_pkg::OP_RORW,  64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFE1,
                6'd0, 1'b0, 64'h0, 1'b0);
        add_row(1'b1, KIND_MAX_CODE, '1, '1, 6'd63, 1'b1, 64'h0, 1'b1);    // unused code
        // 32-bit width: zero counts to 32, word forms illegal, shamt bit 5 ignored
        add_row(1'b0, zbb_pkg::OP_CTZ,   64'hFFFF_FFFF_0000_0000, 64'h0,
                6'd0, 1'b1, 64'd32, 1'b0);
        add_row(1'b0, zbb_pkg::OP_CLZW,  64'h1, 64'h0, 6'd0, 1'b1, 64'h0, 1'b1);
        add_row(1'b0, zbb_pkg::OP_RORI,  '1, 64'h0, 6'd63, 1'b0, 64'h0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].wide != wide_sel)
                set_width(directed_rows[i].wide);
            send_item(directed_rows[i].instr, directed_rows[i].typed,
                      directed_rows[i].result);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            set_width(phase_wide[p]);
            send_idle_pct   = phase_send[p];
            recv_stall_pct <= phase_recv[p];
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // back-pressure phase: ask the master side to hold off a few
                // times while the sender keeps offering
                if (p == 4 && n % 50 == 10)
                    hold_requests <= hold_requests + 1;
                ins = rand_instr();
                send_item(ins, 1'b0, none);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* files.f */
sv/zbb_pkg.sv
sv/zbb_cnt.sv
sv/zbb_bitmanip_alu.sv
verif/testbench.sv
